@@ rtl/tdom_pkg.sv @@
// Package for the trial-division big omega / Mobius / Liouville core.
// Holds widths, the sequencer state type and the sign codes; no dependencies.
`default_nettype none

package tdom_pkg;

    // Width of the number that is factored.
    localparam int N_BITS   = 32;
    // Trial divisors never pass sqrt(2^N_BITS) + 1.
    localparam int P_BITS   = N_BITS / 2 + 1;
    // Bit counter of the shared divider.
    localparam int CNT_BITS = $clog2(N_BITS);
    // Width of the big omega result.
    localparam int FC_BITS  = 6;

    // Two-bit signed codes of the sign results.
    localparam logic [1:0] CODE_ZERO  = 2'b00;
    localparam logic [1:0] CODE_PLUS  = 2'b01;
    localparam logic [1:0] CODE_MINUS = 2'b11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

@@ rtl/trial_division_omega_mobius_core.sv @@
// Top level: trial-division factoring core giving big omega, Mobius and Liouville values.
// Uses tdom_pkg for widths, state type and sign codes.
`default_nettype none

// Each division tried runs one divider step per bit of the number, then one evaluation
// step; divisions are one per trial divisor plus one per prime factor found. The worst
// case is a 32-bit prime, set by the bit-serial restoring divider that every trial shares.
// Throughput: one item at a time; the input is ready only while the sequencer idles.
// Reset (synchronous, active low) idles the sequencer and empties the output register.
module trial_division_omega_mobius_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [31:0]                     i_number,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [tdom_pkg::FC_BITS-1:0]         o_factor_count,
    output logic signed [1:0]                    o_mobius_value,
    output logic signed [1:0]                    o_liouville_value
);

    tdom_pkg::t_state r_state, n_state;

    logic [tdom_pkg::N_BITS-1:0]   r_n, n_n;        // remaining cofactor
    logic [tdom_pkg::P_BITS-1:0]   r_p, n_p;        // trial divisor
    logic [tdom_pkg::N_BITS-1:0]   r_quo, n_quo;    // dividend in, quotient out
    logic [tdom_pkg::P_BITS-1:0]   r_rem, n_rem;    // partial remainder
    logic [tdom_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    logic                          r_inner, n_inner; // dividing out a found prime
    logic [tdom_pkg::FC_BITS-1:0]  r_total, n_total;
    logic                          r_dpar, n_dpar;   // parity of distinct primes
    logic                          r_square, n_square;

    logic                          r_ovalid, n_ovalid;
    logic [tdom_pkg::FC_BITS-1:0]  r_ofc, n_ofc;
    logic [1:0]                    r_omob, n_omob;
    logic [1:0]                    r_oliou, n_oliou;

    logic [tdom_pkg::P_BITS:0]     w_shift;
    logic [tdom_pkg::P_BITS:0]     w_sub;
    logic                          w_ge;
    logic                          w_in_xfer;
    logic                          w_out_free;
    logic                          w_loop_ok;
    logic                          w_left;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_ovalid || i_out_ready;
    // Loop test p <= n / p, taken on the quotient of the last division.
    assign w_loop_ok  = r_quo >= {{(tdom_pkg::N_BITS-tdom_pkg::P_BITS){1'b0}}, r_p};
    assign w_left     = r_n > {{(tdom_pkg::N_BITS-1){1'b0}}, 1'b1};

    // One restoring divider step: shift in the next dividend bit, subtract if it fits.
    assign w_shift = {r_rem, r_quo[tdom_pkg::N_BITS-1]};
    assign w_ge    = w_shift >= {1'b0, r_p};
    assign w_sub   = w_shift - {1'b0, r_p};

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdom_pkg::ST_IDLE: begin
                if (w_in_xfer) n_state = tdom_pkg::ST_DIV;
            end
            tdom_pkg::ST_DIV: begin
                if (r_cnt == '0) n_state = tdom_pkg::ST_EVAL;
            end
            tdom_pkg::ST_EVAL: begin
                if (!r_inner && !w_loop_ok) n_state = tdom_pkg::ST_FINISH;
                else                        n_state = tdom_pkg::ST_DIV;
            end
            tdom_pkg::ST_FINISH: begin
                if (w_out_free) n_state = tdom_pkg::ST_IDLE;
            end
            default: n_state = tdom_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        n_n      = r_n;
        n_p      = r_p;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_inner  = r_inner;
        n_total  = r_total;
        n_dpar   = r_dpar;
        n_square = r_square;
        n_ovalid = r_ovalid && !i_out_ready;
        n_ofc    = r_ofc;
        n_omob   = r_omob;
        n_oliou  = r_oliou;
        unique case (r_state)
            tdom_pkg::ST_IDLE: begin
                // Load a new number and start dividing it by 2.
                n_n      = i_number[tdom_pkg::N_BITS-1:0];
                n_quo    = i_number[tdom_pkg::N_BITS-1:0];
                n_p      = tdom_pkg::P_BITS'(2);
                n_rem    = '0;
                n_cnt    = tdom_pkg::CNT_BITS'(tdom_pkg::N_BITS - 1);
                n_inner  = 1'b0;
                n_total  = '0;
                n_dpar   = 1'b0;
                n_square = 1'b0;
            end
            tdom_pkg::ST_DIV: begin
                n_rem = w_ge ? w_sub[tdom_pkg::P_BITS-1:0] : w_shift[tdom_pkg::P_BITS-1:0];
                n_quo = {r_quo[tdom_pkg::N_BITS-2:0], w_ge};
                n_cnt = r_cnt - 1'b1;
            end
            tdom_pkg::ST_EVAL: begin
                // Divisible: take the factor out and divide the new cofactor again.
                if (r_rem == '0 && (r_inner || w_loop_ok)) begin
                    n_n     = r_quo;
                    n_total = r_total + 1'b1;
                    if (r_inner) n_square = 1'b1;
                    else         n_dpar   = !r_dpar;
                    n_inner = 1'b1;
                end else begin
                    n_p     = r_p + 1'b1;
                    n_inner = 1'b0;
                end
                n_quo = (r_rem == '0 && (r_inner || w_loop_ok)) ? r_quo : r_n;
                n_rem = '0;
                n_cnt = tdom_pkg::CNT_BITS'(tdom_pkg::N_BITS - 1);
            end
            tdom_pkg::ST_FINISH: begin
                // A cofactor above one is a last prime.
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ofc    = r_total + tdom_pkg::FC_BITS'(w_left);
                    if (r_square)            n_omob = tdom_pkg::CODE_ZERO;
                    else if (r_dpar ^ w_left) n_omob = tdom_pkg::CODE_MINUS;
                    else                     n_omob = tdom_pkg::CODE_PLUS;
                    n_oliou  = (r_total[0] ^ w_left) ? tdom_pkg::CODE_MINUS
                                                     : tdom_pkg::CODE_PLUS;
                end
            end
            default: begin
                n_ovalid = r_ovalid;
            end
        endcase
    end

    // Control registers reset; payload registers do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tdom_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_n      <= n_n;
        r_p      <= n_p;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_inner  <= n_inner;
        r_total  <= n_total;
        r_dpar   <= n_dpar;
        r_square <= n_square;
        r_ofc    <= n_ofc;
        r_omob   <= n_omob;
        r_oliou  <= n_oliou;
    end

    assign o_in_ready        = (r_state == tdom_pkg::ST_IDLE);
    assign o_out_valid       = r_ovalid;
    assign o_factor_count    = r_ofc;
    assign o_mobius_value    = r_omob;
    assign o_liouville_value = r_oliou;

    // The remainder of a finished division is below its divisor.
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdom_pkg::ST_EVAL) |-> (r_rem < r_p))
        else $error("remainder not below divisor");

    // An input transfer always starts a division.
    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == tdom_pkg::ST_DIV))
        else $error("accepted item did not start a division");

    // Liouville value follows the parity of big omega.
    a_liou_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_liouville_value ==
            (o_factor_count[0] ? tdom_pkg::CODE_MINUS : tdom_pkg::CODE_PLUS)))
        else $error("liouville value disagrees with factor count");

    // A nonzero Mobius value matches the Liouville value (squarefree case).
    a_mob_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mobius_value != tdom_pkg::CODE_ZERO) |->
            (o_mobius_value == o_liouville_value))
        else $error("mobius sign disagrees with liouville sign");

endmodule

`default_nettype wire
